FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median
// Sizes of the sorted cell chain, cell contents, and the control word that
// goes out to every cell of the chain.
// ----------------------------------------------------------------------------
package swm_pkg;

  // chain depth and sample width
  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int AGE_BITS    = $clog2(WINDOW_MAX);
  localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int CFG_BITS    = 7;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;

  // window size after reset
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_BITS-1:0]           age_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;

  // contents of one sorted cell
  typedef struct packed {
    logic    valid;
    sample_t value;
    age_t    age;
  } cell_t;

  // what a cell shows its neighbours: its contents and where they move
  typedef struct packed {
    cell_t data;
    logic  up;
    logic  dn;
  } link_t;

  // per-cell status gathered by the control
  typedef struct packed {
    logic dropped;
    logic excess;
  } stat_t;

  // control word sent to every cell
  typedef struct packed {
    logic    en;
    logic    ins;
    logic    clr;
    age_t    drop_age;
    cnt_t    win;
    sample_t sample;
  } cmd_t;

  // the leaving cell, as seen by all cells
  typedef struct packed {
    logic    any;
    sample_t value;
  } drop_t;

endpackage

FILE: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one cell of the sorted chain
// Holds one sample and its age. Each update it keeps its contents, takes
// its left or right neighbour's, or loads the new sample, so the chain stays
// sorted while the oldest cell leaves and the new sample enters.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  swm_pkg::cmd_t  cmd,
  input  swm_pkg::drop_t drop,
  input  swm_pkg::link_t left_lk,
  input  swm_pkg::link_t right_lk,
  output swm_pkg::link_t lk,
  output swm_pkg::stat_t st
);
  import swm_pkg::*;

  logic    valid_r, valid_nxt;
  sample_t value_r, value_nxt;
  age_t    age_r, age_nxt;

  logic v;
  logic after_drop;
  logic goes_right;
  logic stay;

  // own flags: leaving, beyond the window, behind the leaving cell, behind the new sample
  always_comb begin
    v          = valid_r && !cmd.clr;
    st.dropped = v && (age_r == cmd.drop_age);
    st.excess  = valid_r && (CNT_BITS'(age_r) >= cmd.win);
    after_drop = drop.any && (!v || ($signed(value_r) > $signed(drop.value)) ||
                 (($signed(value_r) == $signed(drop.value)) && (age_r < cmd.drop_age)));
    goes_right = cmd.ins && (!v || ($signed(value_r) > $signed(cmd.sample)));
    stay       = !st.dropped && (goes_right == after_drop);
    lk.up      = !st.dropped && goes_right && !after_drop;
    lk.dn      = !st.dropped && !goes_right && after_drop;
    lk.data.valid = v;
    lk.data.value = value_r;
    lk.data.age   = age_r;
  end

  // next contents from left, self, right or the new sample
  always_comb begin
    if (left_lk.up) begin
      valid_nxt = left_lk.data.valid;
      value_nxt = left_lk.data.value;
      age_nxt   = left_lk.data.age + age_t'(cmd.ins);
    end else if (stay) begin
      valid_nxt = v;
      value_nxt = value_r;
      age_nxt   = age_r + age_t'(cmd.ins);
    end else if (right_lk.dn) begin
      valid_nxt = right_lk.data.valid;
      value_nxt = right_lk.data.value;
      age_nxt   = right_lk.data.age + age_t'(cmd.ins);
    end else begin
      valid_nxt = cmd.ins;
      value_nxt = cmd.sample;
      age_nxt   = '0;
    end
  end

  // cell registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

FILE: rtl/sliding_window_median.sv
// out_valid rises once the item that completes a result has passed through pend_r and the output register.
// Throughput: one item per cycle while in_stall is low, set by the update of the sorted cell chain.
// After the window is made smaller, in_stall stays high while the ages beyond the window
// are swept out of the chain, one age per cycle while no result is held.
// Reset (synchronous, rst_n low): chain empty, fill count zero, window size 3,
// output register empty.
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the last window_size samples
// Sorted chain of cells with ages; the oldest cell leaves as each new sample
// enters, and twice the median is read from the middle of the chain.
// ----------------------------------------------------------------------------
module sliding_window_median (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [swm_pkg::CFG_BITS-1:0]            cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [swm_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  logic                                    in_start_of_run,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [swm_pkg::OUT_BITS-1:0]     out_median_twice
);
  import swm_pkg::*;

  logic [CFG_BITS-1:0] window_size_r;
  cnt_t                win;
  age_t                purge_age_r, purge_age_nxt;
  cnt_t                fill_r, fill_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [OUT_BITS-1:0] out_data_r, out_data_nxt;

  link_t lk [WINDOW_MAX];
  stat_t st [WINDOW_MAX];
  cmd_t  cmd;
  drop_t drop;

  logic  hold;
  logic  purge_needed;
  logic  purge;
  logic  step;
  logic  res;
  age_t  idx_a, idx_b;
  cnt_t  win_m1;
  sample_t med_a, med_b;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_size_r <= cfg_wr_data;
    end
  end

  // effective window, clamped to 1..WINDOW_MAX
  always_comb begin
    if (window_size_r == '0) begin
      win = CNT_BITS'(1);
    end else if (32'(window_size_r) > 32'(WINDOW_MAX)) begin
      win = CNT_BITS'(WINDOW_MAX);
    end else begin
      win = CNT_BITS'(window_size_r);
    end
  end

  // gather leaving cell and cells beyond the window
  always_comb begin
    drop.any     = 1'b0;
    drop.value   = '0;
    purge_needed = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      drop.any     = drop.any | st[i].dropped;
      drop.value   = drop.value | (lk[i].data.value & {SAMPLE_BITS{st[i].dropped}});
      purge_needed = purge_needed | st[i].excess;
    end
  end

  // handshake and chain control
  always_comb begin
    hold         = pend_r && out_valid_r && out_stall;
    purge        = purge_needed && !hold;
    in_stall     = hold || purge_needed;
    step         = in_valid && !in_stall;
    cmd.en       = step || purge;
    cmd.ins      = step;
    cmd.clr      = step && in_start_of_run;
    cmd.drop_age = step ? AGE_BITS'(win - CNT_BITS'(1)) : purge_age_r;
    cmd.win      = win;
    cmd.sample   = in_sample;
  end

  // age sweep used after the window shrinks
  always_comb begin
    if (purge) begin
      purge_age_nxt = purge_age_r - age_t'(1);
    end else begin
      purge_age_nxt = AGE_BITS'(WINDOW_MAX - 1);
    end
  end

  // fill count and result flag
  always_comb begin
    if (cmd.clr) begin
      fill_nxt = CNT_BITS'(1);
    end else if (cmd.en) begin
      fill_nxt = fill_r - cnt_t'(drop.any) + cnt_t'(cmd.ins);
    end else begin
      fill_nxt = fill_r;
    end
    res      = step && (fill_nxt == win);
    pend_nxt = step ? res : (pend_r && hold);
  end

  // middle cells of the chain
  always_comb begin
    win_m1 = win - CNT_BITS'(1);
    idx_a  = AGE_BITS'(win_m1 >> 1);
    idx_b  = AGE_BITS'(win >> 1);
    med_a  = '0;
    med_b  = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (AGE_BITS'(i) == idx_a) begin
        med_a = lk[i].data.value;
      end
      if (AGE_BITS'(i) == idx_b) begin
        med_b = lk[i].data.value;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!(out_valid_r && out_stall)) begin
      out_valid_nxt = pend_r;
      if (pend_r) begin
        out_data_nxt = {med_a[SAMPLE_BITS-1], med_a} + {med_b[SAMPLE_BITS-1], med_b};
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      purge_age_r <= AGE_BITS'(WINDOW_MAX - 1);
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      purge_age_r <= purge_age_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_twice = out_data_r;

  // sorted cell chain
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    link_t left_lk;
    link_t right_lk;
    if (i == 0) begin : g_first
      assign left_lk = '0;
    end else begin : g_left
      assign left_lk = lk[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_lk = '0;
    end else begin : g_right
      assign right_lk = lk[i+1];
    end
    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .drop     (drop),
      .left_lk  (left_lk),
      .right_lk (right_lk),
      .lk       (lk[i]),
      .st       (st[i])
    );
  end

endmodule

FILE: rtl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the sliding window median
// Watches the top level's ports for reset state, result timing and a
// held result while stalled.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    cfg_wr_en,
  input logic [swm_pkg::CFG_BITS-1:0]            cfg_wr_data,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic signed [swm_pkg::SAMPLE_BITS-1:0]  in_sample,
  input logic                                    in_start_of_run,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [swm_pkg::OUT_BITS-1:0]     out_median_twice
);
  import swm_pkg::*;

  // reset leaves no result pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present right after reset");

  // a fresh result follows an accepted item that went through pend_r and the output register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an accepted item");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_twice))
    else $error("stalled result changed");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
